[rtl/wto_pkg.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared types and codes for the interpolating wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

    // Register indexes on the configuration channel
    localparam logic [3:0] REG_SIZE_MAG   = 4'd0;
    localparam logic [3:0] REG_PHASE_STEP = 4'd1;
    localparam logic [3:0] REG_PULSE_OFS  = 4'd2;
    localparam logic [3:0] REG_PULSE_MODE = 4'd3;
    localparam logic [3:0] REG_USE_AMP    = 4'd4;
    localparam logic [3:0] REG_AMP_START  = 4'd5;
    localparam logic [3:0] REG_AMP_STEP   = 4'd6;
    localparam logic [3:0] REG_START_PH   = 4'd7;

    // Item kinds carried on s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    localparam logic [3:0] SIZE_MAG_RESET = 4'd11;
    localparam logic [4:0] MIN_MAGNITUDE  = 5'd9;

    localparam int INDEX_W  = 14;
    localparam int WORD_W   = 16;
    localparam int SAMPLE_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MUL1,
        ST_MUL2,
        ST_AMP,
        ST_DONE
    } state_t;

endpackage

[rtl/wto_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8193
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/wavetable_oscillator_interp.sv]
// ----------------------------------------------------------------------------
// Interpolating wavetable oscillator
// Phase-accumulator oscillator over a stored table of signed 16-bit words,
// with linear interpolation, an optional pulse product and a ramped amplitude.
// ----------------------------------------------------------------------------
// A load item writes one table word, if its index is in range, and leaves the
// block ready for the next item. A render item is worked on alone: the table
// sits in one memory with one read port, so its neighbouring entries are
// fetched one a cycle (two in plain mode, four in pulse mode), followed by a
// chain of registered multiplies. No new item is taken until it has passed
// the read, drain and multiply states, the second multiply in pulse mode and
// the amplitude step when scaling is on. The result sits in an output
// register, and a new item is taken while it waits to be collected.
module wavetable_oscillator_interp #(
    parameter int MAX_MAGNITUDE = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: table_index [13:0], table_word [29:14], prior_sample [61:30], zeros
    input  logic [63:0] s_tdata,
    // tuser: req_type
    input  logic        s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: sample_out [31:0]
    output logic [31:0] m_tdata
);

    localparam int DEPTH  = (1 << MAX_MAGNITUDE) + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers
    logic [3:0]         size_mag_reg;
    logic [31:0]        phase_step_reg;
    logic [31:0]        pulse_ofs_reg;
    logic               pulse_mode_reg;
    logic               use_amp_reg;
    logic [31:0]        amp_start_reg;
    logic [31:0]        amp_step_reg;

    // Running state
    logic [31:0]        phase_reg;
    logic [31:0]        amp_reg;

    // Sequencer
    wto_pkg::state_t    state_reg, state_next;
    logic [1:0]         rd_cnt_reg, rd_cnt_next;
    logic               rd_issue;
    logic               cap_en_reg;
    logic [1:0]         cap_slot_reg;

    // Datapath
    logic signed [15:0] w_reg [4];
    logic [31:0]        q_reg;
    logic [31:0]        outa_reg, outb_reg;
    logic [31:0]        v_reg;
    logic [31:0]        amp_prod_reg;
    logic [31:0]        prior_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic               s_accept;
    logic               ld_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic [15:0]        rd_data;
    logic [4:0]         mag_eff;
    logic               out_free;

    function automatic logic [31:0] index_of(input logic [31:0] ph, input logic [4:0] m);
        return ph >> (6'd32 - {1'b0, m});
    endfunction

    function automatic logic [15:0] frac_of(input logic [31:0] ph, input logic [4:0] m);
        return 16'(ph >> (5'd16 - m));
    endfunction

    // Rounded high word of a signed 32 by 32 product
    function automatic logic [31:0] mul_round_hi(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] prod;
        logic [63:0]        sum;
        prod = a * b;
        sum  = prod + 64'h0000_0000_8000_0000;
        return sum[63:32];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == wto_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign ld_we     = s_accept && (s_tuser == wto_pkg::REQ_LOAD)
                       && (32'(s_tdata[13:0]) <= 32'(DEPTH - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        if (size_mag_reg < 4'(wto_pkg::MIN_MAGNITUDE)) begin
            mag_eff = wto_pkg::MIN_MAGNITUDE;
        end else if ({1'b0, size_mag_reg} > 5'(MAX_MAGNITUDE)) begin
            mag_eff = 5'(MAX_MAGNITUDE);
        end else begin
            mag_eff = {1'b0, size_mag_reg};
        end
    end

    // Entries are fetched in the order: A, A+1, B, B+1.
    always_comb begin
        case (rd_cnt_reg)
            2'd0:    rd_addr = ADDR_W'(index_of(phase_reg, mag_eff));
            2'd1:    rd_addr = ADDR_W'(index_of(phase_reg, mag_eff)) + ADDR_W'(1);
            2'd2:    rd_addr = ADDR_W'(index_of(q_reg, mag_eff));
            default: rd_addr = ADDR_W'(index_of(q_reg, mag_eff)) + ADDR_W'(1);
        endcase
    end

    wto_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ld_we),
        .waddr (ADDR_W'(s_tdata[13:0])),
        .wdata (s_tdata[29:14]),
        .re    (rd_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Sequencer: next state
    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        rd_issue    = 1'b0;
        case (state_reg)
            wto_pkg::ST_IDLE: begin
                rd_cnt_next = 2'd0;
                if (s_accept && s_tuser == wto_pkg::REQ_RENDER) begin
                    state_next = wto_pkg::ST_READ;
                end
            end
            wto_pkg::ST_READ: begin
                rd_issue    = 1'b1;
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == (pulse_mode_reg ? 2'd3 : 2'd1)) begin
                    state_next = wto_pkg::ST_DRAIN;
                end
            end
            wto_pkg::ST_DRAIN: begin
                state_next = wto_pkg::ST_MUL1;
            end
            wto_pkg::ST_MUL1: begin
                if (pulse_mode_reg) begin
                    state_next = wto_pkg::ST_MUL2;
                end else if (use_amp_reg) begin
                    state_next = wto_pkg::ST_AMP;
                end else begin
                    state_next = wto_pkg::ST_DONE;
                end
            end
            wto_pkg::ST_MUL2: begin
                state_next = use_amp_reg ? wto_pkg::ST_AMP : wto_pkg::ST_DONE;
            end
            wto_pkg::ST_AMP: begin
                state_next = wto_pkg::ST_DONE;
            end
            wto_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = wto_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wto_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wto_pkg::ST_IDLE;
            rd_cnt_reg <= 2'd0;
            cap_en_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            cap_en_reg <= rd_issue;
        end
    end

    // Interpolation arithmetic
    logic [15:0]        frac_a, frac_b;
    logic signed [16:0] diff;
    logic signed [32:0] plain_prod;
    logic [31:0]        v_plain;
    logic signed [31:0] pa_hi;
    logic signed [32:0] pa_lo;
    logic signed [33:0] sum_a;
    logic signed [31:0] pb_hi, pb_lo;
    logic signed [32:0] sum_b;
    logic [31:0]        half_amp;

    always_comb begin
        frac_a     = frac_of(phase_reg, mag_eff);
        frac_b     = frac_of(q_reg, mag_eff);
        diff       = {w_reg[1][15], w_reg[1]} - {w_reg[0][15], w_reg[0]};
        plain_prod = diff * $signed({1'b0, frac_a[15:1]});
        v_plain    = {w_reg[0], 16'h0000} + {plain_prod[30:0], 1'b0};
        // First lookup weights: minus the fraction on the upper entry, and
        // the fraction with the top bit set on the lower entry.
        pa_hi      = $signed({1'b0, frac_a[14:0]}) * w_reg[1];
        pa_lo      = $signed({2'b01, frac_a[14:0]}) * w_reg[0];
        sum_a      = pa_lo - pa_hi;
        pb_hi      = $signed({1'b0, frac_b[14:0]}) * w_reg[3];
        pb_lo      = $signed({1'b0, ~frac_b[14:0]}) * w_reg[2];
        sum_b      = pb_hi + pb_lo;
        half_amp   = {amp_reg[31], amp_reg[31:1]};
    end

    always_ff @(posedge aclk) begin
        if (cap_en_reg) begin
            w_reg[cap_slot_reg] <= rd_data;
        end
        cap_slot_reg <= rd_cnt_reg;
        if (state_reg == wto_pkg::ST_READ && rd_cnt_reg == 2'd0) begin
            q_reg <= phase_reg + pulse_ofs_reg;
        end
        if (s_accept) begin
            prior_reg <= s_tdata[61:30];
        end
        if (state_reg == wto_pkg::ST_MUL1) begin
            v_reg    <= v_plain;
            outa_reg <= {sum_a[30:0], 1'b0};
            outb_reg <= {sum_b[30:0], 1'b0};
        end
        if (state_reg == wto_pkg::ST_MUL2) begin
            v_reg <= mul_round_hi(outa_reg, outb_reg) << 1;
        end
        if (state_reg == wto_pkg::ST_AMP) begin
            amp_prod_reg <= mul_round_hi(v_reg, half_amp);
        end
        if (state_reg == wto_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= use_amp_reg ? prior_reg + {amp_prod_reg[30:0], 1'b0} : v_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == wto_pkg::ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Configuration and running phase and amplitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_mag_reg   <= wto_pkg::SIZE_MAG_RESET;
            phase_step_reg <= 32'd0;
            pulse_ofs_reg  <= 32'd0;
            pulse_mode_reg <= 1'b0;
            use_amp_reg    <= 1'b0;
            amp_start_reg  <= 32'd0;
            amp_step_reg   <= 32'd0;
            phase_reg      <= 32'd0;
            amp_reg        <= 32'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wto_pkg::REG_SIZE_MAG:   size_mag_reg   <= cfg_data[3:0];
                    wto_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data;
                    wto_pkg::REG_PULSE_OFS:  pulse_ofs_reg  <= cfg_data;
                    wto_pkg::REG_PULSE_MODE: pulse_mode_reg <= cfg_data[0];
                    wto_pkg::REG_USE_AMP:    use_amp_reg    <= cfg_data[0];
                    wto_pkg::REG_AMP_START: begin
                        amp_start_reg <= cfg_data;
                        amp_reg       <= cfg_data;
                    end
                    wto_pkg::REG_AMP_STEP:   amp_step_reg   <= cfg_data;
                    wto_pkg::REG_START_PH: begin
                        phase_reg <= cfg_data;
                        amp_reg   <= amp_start_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_accept && s_tuser == wto_pkg::REQ_RENDER) begin
                phase_reg <= phase_reg + phase_step_reg;
                amp_reg   <= amp_reg + amp_step_reg;
            end
        end
    end

endmodule

[rtl/wto_checker.sv]
// ----------------------------------------------------------------------------
// Wavetable oscillator checker
// Port-level properties of the oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module wto_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A render transfer leaves the block busy, so s_tready drops.
    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == wto_pkg::REQ_RENDER |=> !s_tready)
        else $error("input taken straight after a render item");

    // A load item never produces a result.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == wto_pkg::REQ_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a load item");

endmodule

bind wavetable_oscillator_interp wto_port_checker u_wto_checker (.*);
